@@ design/cpp_pkg.sv @@
// Package for the closest point on polyline block: widths, sizes and shared types.
// Used by cpp_ctrl, cpp_dp and closest_point_on_polyline.
package cpp_pkg;
  localparam int COORD_W = 32;
  localparam int IDX_W = 10;
  localparam int MAX_WAYPOINTS = 1024;
  localparam int T_FRAC_BITS = 32;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUERY_Z = 2'd2;

  // Datapath operations, one per controller step.
  typedef enum logic [3:0] {
    OP_NONE,    // hold
    OP_LOAD,    // latch waypoint, form differences
    OP_MUL,     // one product into the accumulators (step selects which)
    OP_DECIDE,  // choose start, end or divide
    OP_DIV,     // one restoring divider step
    OP_INTERP,  // one interpolation product (step selects axis)
    OP_DIST,    // one squared-distance product (step selects axis)
    OP_UPDATE,  // compare with best and finish the waypoint
    OP_SKIP     // first waypoint: latch as previous and count it
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] step;
  } cmd_t;

  typedef struct packed {
    logic need_div;
  } status_t;
endpackage

@@ design/closest_point_on_polyline.sv @@
// Top level of the closest point on polyline block.
// Depends on cpp_pkg, cpp_ctrl and cpp_dp.
//
// Usage: write query_x/y/z (index 0..2) on the cfg channel while idle. Stream
// waypoints on s_axis, one beat each: tdata = {z, y, x}, no tuser,
// tlast marks the final waypoint of a path. For that path a single result beat
// appears on m_axis carrying found, index and the nearest point.
// Each waypoint after the first runs products, decide, the 32-step serial divider
// for t and interpolation unless the projection clamps, then distance and update;
// the shared multiplier takes one product per cycle. A first waypoint is only latched.
// A last waypoint then moves the result into the output register in S_EMIT.
// That register lets the next path start while the result waits; if a later last
// waypoint finishes while it is still full, the controller holds and s_axis_tready
// stays low until the receiver takes the waiting beat.
// Reset clears the query, the path state and any pending result.
module closest_point_on_polyline (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,  // wp_x[31:0], wp_y[63:32], wp_z[95:64]
  input  logic         s_axis_tlast,  // last_wp
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [111:0] m_axis_tdata,  // seg_end_index[9:0], near_x, near_y, near_z, pad
  output logic         m_axis_tuser,  // found
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [cpp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]  cfg_data
);
  import cpp_pkg::*;

  logic signed [COORD_W-1:0] q_x, q_y, q_z;
  cmd_t cmd;
  status_t stat;
  logic busy, emit, in_fire, first_wp, out_free;
  logic r_found;
  logic [IDX_W-1:0] r_idx;
  logic signed [COORD_W-1:0] r_x, r_y, r_z;
  logic [IDX_W-1:0] cnt_zero_unused;
  logic seen;

  assign cfg_ready = 1'b1;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !busy;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign first_wp = !seen;
  assign cnt_zero_unused = '0;

  // Query registers and path-start tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      q_x <= '0; q_y <= '0; q_z <= '0;
      seen <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_QUERY_X: q_x <= cfg_data;
          REG_QUERY_Y: q_y <= cfg_data;
          REG_QUERY_Z: q_z <= cfg_data;
          default: ;
        endcase
      end
      if (in_fire) seen <= !s_axis_tlast;
    end
  end

  cpp_ctrl u_ctrl (
    .clk, .rst, .in_fire, .in_last(s_axis_tlast), .first_wp, .stat, .cmd,
    .busy, .emit, .out_free
  );

  cpp_dp u_dp (
    .clk, .rst, .cmd, .stat,
    .in_x(s_axis_tdata[31:0]), .in_y(s_axis_tdata[63:32]), .in_z(s_axis_tdata[95:64]),
    .q_x, .q_y, .q_z, .clear(emit),
    .res_found(r_found), .res_index(r_idx), .res_x(r_x), .res_y(r_y), .res_z(r_z)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (emit) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    if (emit) begin
      m_axis_tuser <= r_found;
      m_axis_tdata <= {6'd0, r_z, r_y, r_x, r_idx | cnt_zero_unused};
    end
  end
endmodule

@@ design/cpp_dp.sv @@
// Datapath: difference registers, one shared 34x34 multiplier, accumulators,
// serial restoring divider and best-candidate registers. Depends on cpp_pkg.
module cpp_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  cpp_pkg::cmd_t                    cmd,
  output cpp_pkg::status_t                 stat,
  input  logic signed [cpp_pkg::COORD_W-1:0] in_x,
  input  logic signed [cpp_pkg::COORD_W-1:0] in_y,
  input  logic signed [cpp_pkg::COORD_W-1:0] in_z,
  input  logic signed [cpp_pkg::COORD_W-1:0] q_x,
  input  logic signed [cpp_pkg::COORD_W-1:0] q_y,
  input  logic signed [cpp_pkg::COORD_W-1:0] q_z,
  input  logic                             clear,
  output logic                             res_found,
  output logic [cpp_pkg::IDX_W-1:0]        res_index,
  output logic signed [cpp_pkg::COORD_W-1:0] res_x,
  output logic signed [cpp_pkg::COORD_W-1:0] res_y,
  output logic signed [cpp_pkg::COORD_W-1:0] res_z
);
  import cpp_pkg::*;

  logic signed [COORD_W-1:0] prev [3];
  logic signed [COORD_W-1:0] cur [3];
  logic signed [COORD_W-1:0] pq [3];
  logic signed [COORD_W:0] ab [3];
  logic signed [COORD_W:0] ap [3];
  logic signed [COORD_W-1:0] c [3];
  logic [IDX_W-1:0] wp_count;
  logic signed [67:0] dot;
  logic [67:0] nn;
  logic [67:0] rem;
  logic [T_FRAC_BITS-1:0] t;
  logic [64:0] d2;
  logic [63:0] best_d2;
  logic best_valid;
  logic [IDX_W-1:0] best_index;
  logic signed [COORD_W-1:0] best_c [3];

  // Incoming waypoint and live query as arrays indexed by axis.
  logic signed [COORD_W-1:0] in_v [3];
  logic signed [COORD_W-1:0] q_in [3];

  // Shared multiplier operands.
  logic signed [COORD_W+1:0] ma, mb;
  logic signed [2*COORD_W+3:0] prod;
  logic [1:0] ax;
  logic [67:0] rem_sh;
  logic [COORD_W:0] abs_ab;
  logic [64:0] tm;
  logic signed [COORD_W+1:0] dc;

  assign in_v[0] = in_x;
  assign in_v[1] = in_y;
  assign in_v[2] = in_z;
  assign q_in[0] = q_x;
  assign q_in[1] = q_y;
  assign q_in[2] = q_z;

  assign ax = (cmd.step[1:0] == 2'd3) ? 2'd0 : cmd.step[1:0];
  assign abs_ab = ab[ax][COORD_W] ? -ab[ax] : ab[ax];
  assign dc = {{2{pq[ax][COORD_W-1]}}, pq[ax]} - {{2{c[ax][COORD_W-1]}}, c[ax]};

  // Operand selection: in OP_MUL, step 0..2 are dot terms, 4..6 norm terms.
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_MUL: begin
        ma = {ab[ax][COORD_W], ab[ax]};
        mb = cmd.step[2] ? {ab[ax][COORD_W], ab[ax]} : {ap[ax][COORD_W], ap[ax]};
      end
      OP_INTERP: begin
        ma = {2'b00, t};
        mb = {1'b0, abs_ab};
      end
      OP_DIST: begin
        ma = dc;
        mb = dc;
      end
      default: ;
    endcase
  end
  assign prod = ma * mb;
  assign tm = 65'(prod) + 65'(64'h8000_0000);
  assign rem_sh = {rem[66:0], 1'b0};
  assign stat.need_div = (nn != '0) && (dot > 0) && ($unsigned(dot) < nn);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      prev <= '{default: '0};
      wp_count <= '0;
      best_valid <= 1'b0;
      best_d2 <= '1;
      best_index <= '0;
      best_c <= '{default: '0};
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          cur[0] <= in_x; cur[1] <= in_y; cur[2] <= in_z;
          pq[0] <= q_x; pq[1] <= q_y; pq[2] <= q_z;
          for (int k = 0; k < 3; k++) begin
            ab[k] <= {in_v[k][COORD_W-1], in_v[k]} - {prev[k][COORD_W-1], prev[k]};
            ap[k] <= {q_in[k][COORD_W-1], q_in[k]} - {prev[k][COORD_W-1], prev[k]};
          end
          dot <= '0;
          nn <= '0;
          d2 <= '0;
        end
        OP_MUL: begin
          if (cmd.step[2]) nn <= nn + 68'(prod);
          else dot <= dot + 68'(prod);
        end
        OP_DECIDE: begin
          rem <= $unsigned(dot);
          t <= '0;
          if (nn == '0 || dot <= 0) c <= prev;
          else if ($unsigned(dot) >= nn) c <= cur;
          else c <= prev;
        end
        OP_DIV: begin
          if (rem_sh >= nn) begin
            rem <= rem_sh - nn;
            t <= {t[T_FRAC_BITS-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            t <= {t[T_FRAC_BITS-2:0], 1'b0};
          end
        end
        OP_INTERP: begin
          if (ab[ax][COORD_W]) c[ax] <= prev[ax] - COORD_W'(tm[64:T_FRAC_BITS]);
          else c[ax] <= prev[ax] + COORD_W'(tm[64:T_FRAC_BITS]);
        end
        OP_DIST: begin
          d2 <= (d2 + 65'(prod[2*COORD_W+1:0]) > 65'(64'hFFFF_FFFF_FFFF_FFFF)) ?
                65'(64'hFFFF_FFFF_FFFF_FFFF) : d2 + 65'(prod[2*COORD_W+1:0]);
        end
        OP_UPDATE: begin
          if (!best_valid || d2[63:0] < best_d2) begin
            best_valid <= 1'b1;
            best_d2 <= d2[63:0];
            best_index <= wp_count;
            best_c <= c;
          end
          prev <= cur;
          if (wp_count != IDX_W'(MAX_WAYPOINTS - 1)) wp_count <= wp_count + 1'b1;
        end
        OP_SKIP: begin
          prev[0] <= in_x; prev[1] <= in_y; prev[2] <= in_z;
          if (wp_count != IDX_W'(MAX_WAYPOINTS - 1)) wp_count <= wp_count + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Result view of the best candidate; the output register samples it on emit.
  assign res_found = best_valid;
  assign res_index = best_valid ? best_index : '0;
  assign res_x = best_valid ? best_c[0] : '0;
  assign res_y = best_valid ? best_c[1] : '0;
  assign res_z = best_valid ? best_c[2] : '0;
endmodule

@@ design/cpp_ctrl.sv @@
// Controller: sequences load, products, decide, divide, interpolate, distance, update and emit.
// Depends on cpp_pkg.
module cpp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_fire,
  input  logic             in_last,
  input  logic             first_wp,
  input  cpp_pkg::status_t stat,
  output cpp_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             emit,
  input  logic             out_free
);
  import cpp_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_DECIDE, S_DIV, S_INTERP, S_DIST, S_UPDATE,
                            S_EMIT} state_t;
  state_t state;
  logic [5:0] cnt;
  logic last_r;

  // Commands follow the state and counter.
  always_comb begin
    cmd.op = OP_NONE;
    cmd.step = cnt[2:0];
    case (state)
      S_IDLE: begin
        if (in_fire) cmd.op = first_wp ? OP_SKIP : OP_LOAD;
      end
      S_MUL: cmd.op = OP_MUL;
      S_DECIDE: cmd.op = OP_DECIDE;
      S_DIV: cmd.op = OP_DIV;
      S_INTERP: cmd.op = OP_INTERP;
      S_DIST: cmd.op = OP_DIST;
      S_UPDATE: cmd.op = OP_UPDATE;
      default: ;
    endcase
  end
  assign busy = (state != S_IDLE);
  assign emit = (state == S_EMIT) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      last_r <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (in_fire) begin
          last_r <= in_last;
          cnt <= '0;
          if (first_wp) state <= in_last ? S_EMIT : S_IDLE;
          else state <= S_MUL;
        end
        S_MUL: begin
          // Steps 0,1,2 dot; 4,5,6 norm.
          if (cnt == 6'd6) state <= S_DECIDE;
          else cnt <= (cnt == 6'd2) ? 6'd4 : cnt + 1'b1;
        end
        S_DECIDE: begin
          cnt <= '0;
          state <= stat.need_div ? S_DIV : S_DIST;
        end
        S_DIV: begin
          if (cnt == 6'(T_FRAC_BITS - 1)) begin
            cnt <= '0;
            state <= S_INTERP;
          end else cnt <= cnt + 1'b1;
        end
        S_INTERP: begin
          if (cnt == 6'd2) begin
            cnt <= '0;
            state <= S_DIST;
          end else cnt <= cnt + 1'b1;
        end
        S_DIST: begin
          if (cnt == 6'd2) state <= S_UPDATE;
          else cnt <= cnt + 1'b1;
        end
        S_UPDATE: state <= last_r ? S_EMIT : S_IDLE;
        S_EMIT: if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

@@ tb/sv/closest_point_on_polyline_checker.sv @@
// Checker for closest_point_on_polyline: watches the config, waypoint and result channels,
// predicts each path result and compares it field by field. Depends on cpp_pkg.
`timescale 1ns / 100ps
module closest_point_on_polyline_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [95:0]                   s_axis_tdata,
  input  logic                          s_axis_tlast,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [111:0]                  m_axis_tdata,
  input  logic                          m_axis_tuser,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [cpp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  output int                            errors,
  output int                            pending,
  output int                            paths_done
);
  import cpp_pkg::*;

  typedef struct packed {
    logic        found;
    logic [9:0]  idx;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } nearest_t;

  nearest_t   nearest_q[$];
  longint     query[3];
  longint     prev_pt[3];
  int         wp_seen;
  bit [63:0]  best_d2;
  bit         best_valid;
  int         best_idx;
  longint     best_pt[3];

  function automatic bit [63:0] umag(longint d);
    return (d < 0) ? 64'(-d) : 64'(d);
  endfunction

  function automatic longint sx32(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function void clear_path();
    for (int k = 0; k < 3; k++) begin
      prev_pt[k] = 0;
      best_pt[k] = 0;
    end
    wp_seen = 0;
    best_d2 = '1;
    best_valid = 0;
    best_idx = 0;
  endfunction

  // Project the query onto segment prev->b, clamp, and keep it if strictly nearer.
  function void eval_segment(longint b[3], int idx);
    longint    ab[3], ap[3], c[3];
    bit [127:0] pos, neg, nn, dot, rem;
    bit [63:0]  pr, t, m, prod, d2;
    bit [64:0]  s;
    pos = 0;
    neg = 0;
    nn = 0;
    d2 = 0;
    t = 0;
    for (int k = 0; k < 3; k++) begin
      ab[k] = b[k] - prev_pt[k];
      ap[k] = query[k] - prev_pt[k];
      pr = umag(ap[k]) * umag(ab[k]);
      if ((ap[k] < 0) != (ab[k] < 0)) neg = neg + pr;
      else pos = pos + pr;
      pr = umag(ab[k]) * umag(ab[k]);
      nn = nn + pr;
    end
    if (nn == 0 || neg >= pos) begin
      c = prev_pt;
    end else begin
      dot = pos - neg;
      if (dot >= nn) begin
        c = b;
      end else begin
        rem = dot;
        for (int i = 0; i < T_FRAC_BITS; i++) begin
          rem = rem << 1;
          t = t << 1;
          if (rem >= nn) begin
            rem = rem - nn;
            t[0] = 1'b1;
          end
        end
        // Products wrap at 64 bits, as in the fixed-point definition.
        for (int k = 0; k < 3; k++) begin
          prod = t * umag(ab[k]);
          prod = prod + 64'h8000_0000;
          m = prod >> T_FRAC_BITS;
          c[k] = (ab[k] < 0) ? prev_pt[k] - longint'(m) : prev_pt[k] + longint'(m);
        end
      end
    end
    for (int k = 0; k < 3; k++) begin
      m = umag(query[k] - c[k]);
      pr = m * m;
      s = {1'b0, d2} + {1'b0, pr};
      d2 = s[64] ? '1 : s[63:0];
    end
    if (!best_valid || d2 < best_d2) begin
      best_valid = 1;
      best_d2 = d2;
      best_idx = idx;
      best_pt = c;
    end
  endfunction

  function void take_waypoint(logic [95:0] data, logic last);
    longint   b[3];
    nearest_t r;
    b[0] = sx32(data[31:0]);
    b[1] = sx32(data[63:32]);
    b[2] = sx32(data[95:64]);
    if (wp_seen > 0) eval_segment(b, wp_seen);
    prev_pt = b;
    if (wp_seen < MAX_WAYPOINTS - 1) wp_seen++;
    if (last) begin
      r.found = best_valid;
      r.idx = best_valid ? 10'(best_idx) : '0;
      r.x = best_valid ? 32'(best_pt[0]) : '0;
      r.y = best_valid ? 32'(best_pt[1]) : '0;
      r.z = best_valid ? 32'(best_pt[2]) : '0;
      nearest_q.push_back(r);
      clear_path();
    end
  endfunction

  // Compare one result beat against the oldest prediction.
  function void check_result(logic [111:0] data, logic user);
    nearest_t got, want;
    got.found = user;
    got.idx = data[9:0];
    got.x = data[41:10];
    got.y = data[73:42];
    got.z = data[105:74];
    if (nearest_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result beat found=%0d idx=%0d x=%h y=%h z=%h",
               $time, got.found, got.idx, got.x, got.y, got.z);
      return;
    end
    want = nearest_q.pop_front();
    paths_done++;
    if (got !== want) begin
      errors++;
      $display("%0t: result mismatch expected found=%0d idx=%0d x=%h y=%h z=%h", $time,
               want.found, want.idx, want.x, want.y, want.z);
      $display("%0t:                   actual found=%0d idx=%0d x=%h y=%h z=%h", $time,
               got.found, got.idx, got.x, got.y, got.z);
    end
  endfunction

  initial begin
    errors = 0;
    paths_done = 0;
    for (int k = 0; k < 3; k++) query[k] = 0;
    clear_path();
  end

  // Track every beat on the three channels.
  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) query[k] = 0;
      clear_path();
      nearest_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_QUERY_X: query[0] = sx32(cfg_data);
          REG_QUERY_Y: query[1] = sx32(cfg_data);
          REG_QUERY_Z: query[2] = sx32(cfg_data);
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata, m_axis_tuser);
      if (s_axis_tvalid && s_axis_tready) take_waypoint(s_axis_tdata, s_axis_tlast);
    end
    pending = nearest_q.size();
  end
endmodule

@@ tb/sv/closest_point_on_polyline_tb.sv @@
// Testbench top for closest_point_on_polyline: drives query writes and waypoint paths,
// stalls the result side, and reports the verdict. Depends on cpp_pkg and the checker.
`timescale 1ns / 100ps
module closest_point_on_polyline_tb;
  import cpp_pkg::*;

  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] CMAX = 32'h7fff_ffff;
  localparam logic [31:0] CMIN = 32'h8000_0000;
  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 1500;

  logic                 clk;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [95:0]          s_axis_tdata;
  logic                 s_axis_tlast;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [111:0]         m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;
  int                   errors;
  int                   pending;
  int                   paths_done;
  int                   idle_cycles;
  int                   burst_left;
  int                   wp_sent;
  bit                   hold_req;

  closest_point_on_polyline dut (.*);

  closest_point_on_polyline_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Receiver: the stall pattern changes at random between phases; a long hold-off on request.
  initial begin
    int hold_cnt, mode, phase_cnt;
    hold_cnt = 0;
    mode = 0;
    phase_cnt = 0;
    m_axis_tready = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        hold_cnt = HOLD_CYCLES;
      end
      if (phase_cnt == 0) begin
        mode = $urandom_range(0, 2);
        phase_cnt = 64;
      end
      phase_cnt--;
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready <= 0;
      end else begin
        case (mode)
          0: m_axis_tready <= 1;
          1: m_axis_tready <= ($urandom_range(0, 1) == 1);
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Watchdog on cycles with no beat on any channel.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // One register write beat; the caller drops cfg_valid after the last one.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Query writes only once every result is out and the datapath has drained.
  task automatic set_query(logic [31:0] qx, logic [31:0] qy, logic [31:0] qz);
    s_axis_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    write_reg(REG_QUERY_X, qx);
    write_reg(REG_QUERY_Y, qy);
    write_reg(REG_QUERY_Z, qz);
    cfg_valid <= 0;
  endtask

  // One waypoint beat, with bursts separated by random gaps.
  task automatic send_wp(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic last);
    if (burst_left == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tvalid <= 1;
    s_axis_tdata <= {z, y, x};
    s_axis_tlast <= last;
    do @(posedge clk); while (!s_axis_tready);
    wp_sent++;
  endtask

  function automatic logic [31:0] rand_coord(int spread);
    case (spread)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      default: return ($urandom_range(0, 1) == 1) ? CMAX : CMIN;
    endcase
  endfunction

  // A path of n waypoints; spread picks the coordinate range.
  task automatic send_path(int n, int spread);
    int sp;
    for (int i = 0; i < n; i++) begin
      sp = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : spread;
      send_wp(rand_coord(sp), rand_coord(sp), rand_coord(sp), i == n - 1);
    end
  endtask

  initial begin
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    s_axis_tlast = 0;
    cfg_valid = 0;
    cfg_index = REG_QUERY_X;
    cfg_data = '0;
    hold_req = 0;
    burst_left = 0;
    wp_sent = 0;
    rst = 1;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: a path with no segment, under the reset query.
    send_wp(ONE, ONE, ONE, 1);
    set_query(ONE, ONE, '0);
    // Interior projection, a tie with the earlier segment, a clamp to the start,
    // and a zero-length segment.
    send_wp('0, '0, '0, 0);
    send_wp(2 * ONE, '0, '0, 0);
    send_wp(2 * ONE, 2 * ONE, '0, 0);
    send_wp(5 * ONE, 5 * ONE, '0, 0);
    send_wp(5 * ONE, 5 * ONE, '0, 1);
    // Zero-length first segment, then a clamp to the segment end.
    send_wp(-32'sd3 * ONE, '0, '0, 0);
    send_wp(-32'sd3 * ONE, '0, '0, 0);
    send_wp(-32'sd2 * ONE, '0, '0, 1);
    // Coordinate extremes, with the query at each extreme as well.
    send_wp(CMIN, CMIN, CMIN, 0);
    send_wp(CMAX, CMAX, CMAX, 0);
    send_wp(CMIN, CMAX, CMIN, 1);
    set_query(CMAX, CMIN, CMAX);
    send_wp(CMIN, CMIN, CMIN, 0);
    send_wp(CMAX, CMAX, CMAX, 0);
    send_wp(CMAX, CMIN, CMIN, 1);

    // Random: an overlong path so the index saturates, then short paths.
    set_query($urandom_range(0, 1 << 20), $urandom_range(0, 1 << 20), '0);
    send_path(1030, 1);
    for (int p = 0; p < 20; p++) send_path($urandom_range(1, 8), 1);
    set_query(CMAX, CMAX, CMAX);
    for (int p = 0; p < 12; p++) send_path($urandom_range(1, 8), $urandom_range(0, 2));
    set_query(CMIN, CMIN, CMIN);
    for (int p = 0; p < 12; p++) send_path($urandom_range(1, 8), $urandom_range(0, 2));
    set_query($urandom, $urandom, $urandom);
    for (int p = 0; p < 8; p++) send_path($urandom_range(1, 8), 0);
    // Long receiver hold-off while short paths keep arriving.
    hold_req = 1;
    for (int p = 0; p < 6; p++) send_path($urandom_range(1, 3), 0);
    for (int p = 0; p < 10; p++) send_path($urandom_range(1, 8), 1);
    s_axis_tvalid <= 0;

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d waypoints; %0d path results checked.", wp_sent, paths_done);
    $display("Covered empty paths, ties, clamps, index saturation and a long output stall.");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
design/cpp_pkg.sv
design/cpp_dp.sv
design/cpp_ctrl.sv
design/closest_point_on_polyline.sv
tb/sv/closest_point_on_polyline_checker.sv
tb/sv/closest_point_on_polyline_tb.sv
